/* src/sbfr_pkg.sv */
// Shared types and constants for the sync byte frame receiver.
package sbfr_pkg;

    localparam int unsigned MAX_FRAME = 64;

    localparam int unsigned LEN_W = 7;
    localparam int unsigned TMR_W = 16;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic             store_valid;
        logic [IDX_W-1:0] store_index;
        logic [7:0]       store_data;
        logic             frame_done;
        logic             frame_held;
        logic             timeout_drop;
    } out_t;

    typedef struct packed {
        logic [7:0]       sync_value;
        logic [LEN_W-1:0] frame_length;
        logic [TMR_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

/* src/sync_byte_frame_receiver.sv */
// Top level of the sync byte frame receiver: input register, framer, result register.
//
// Channel | Direction | Handshake            | Payload
// in      | request   | in_valid / in_ready   | in_data (func, rx_byte)
// out     | result    | out_valid / out_ready | out_data (store and status fields)
// cfg     | write     | cfg_write             | cfg_index, cfg_data
//
// One request per cycle unless the result stalls; the result is registered.
// The framer state advances as a request moves from the input register
// into the result register. A stalled result holds both registers; the
// input register still takes a request while it is empty.
// Reset clears all control state and loads register defaults.
module sync_byte_frame_receiver
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sbfr_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sbfr_pkg::out_t                   out_data,
    input  logic                             cfg_write,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic           s1_valid_reg;
    sbfr_pkg::in_t  s1_item_reg;
    logic           out_valid_reg;
    sbfr_pkg::out_t out_data_reg;

    logic           advance;
    sbfr_pkg::cfg_t cfg;
    sbfr_pkg::out_t res;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    sbfr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbfr_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (s1_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_data;
        if (advance)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/sbfr_cfg.sv */
// Configuration register bank for the sync byte frame receiver.
module sbfr_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sbfr_pkg::cfg_t                     cfg
);

    sbfr_pkg::cfg_t cfg_reg;
    sbfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                sbfr_pkg::REG_SYNC_VALUE:
                    cfg_next.sync_value = cfg_data[7:0];
                sbfr_pkg::REG_FRAME_LENGTH:
                    cfg_next.frame_length = cfg_data[sbfr_pkg::LEN_W-1:0];
                sbfr_pkg::REG_TIMEOUT_TICKS:
                    cfg_next.timeout_ticks = cfg_data[sbfr_pkg::TMR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value    <= 8'd0;
            cfg_reg.frame_length  <= sbfr_pkg::LEN_W'(8);
            cfg_reg.timeout_ticks <= sbfr_pkg::TMR_W'(100);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/sbfr_core.sv */
// Framer state and per-request update logic.
module sbfr_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  sbfr_pkg::in_t      item,
    input  sbfr_pkg::cfg_t     cfg,
    output sbfr_pkg::out_t     res
);

    localparam logic [sbfr_pkg::LEN_W-1:0] LEN_MIN = sbfr_pkg::LEN_W'(2);
    localparam logic [sbfr_pkg::LEN_W-1:0] LEN_MAX = sbfr_pkg::LEN_W'(sbfr_pkg::MAX_FRAME);

    logic                         collecting_reg, collecting_next;
    logic [sbfr_pkg::LEN_W-1:0]   count_reg, count_next;
    logic                         held_reg, held_next;
    logic                         timed_out_reg, timed_out_next;
    logic [sbfr_pkg::TMR_W-1:0]   tmr_count_reg, tmr_count_next;
    logic                         tmr_run_reg, tmr_run_next;

    logic [sbfr_pkg::LEN_W-1:0]   len;
    logic [sbfr_pkg::TMR_W-1:0]   lim;
    logic [sbfr_pkg::TMR_W-1:0]   tmr_inc;

    always_comb
    begin
        len = cfg.frame_length;
        if (len < LEN_MIN)
            len = LEN_MIN;
        if (len > LEN_MAX)
            len = LEN_MAX;
        lim = (cfg.timeout_ticks == '0) ? sbfr_pkg::TMR_W'(1) : cfg.timeout_ticks;
        tmr_inc = tmr_count_reg + sbfr_pkg::TMR_W'(1);
    end

    always_comb
    begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        timed_out_next  = timed_out_reg;
        tmr_count_next  = tmr_count_reg;
        tmr_run_next    = tmr_run_reg;
        res             = '0;

        case (item.func)
            sbfr_pkg::FUNC_BYTE:
            begin
                if (!held_reg)
                begin
                    if (!collecting_reg)
                    begin
                        count_next     = '0;
                        timed_out_next = 1'b0;
                        if (item.rx_byte == cfg.sync_value)
                        begin
                            res.store_valid = 1'b1;
                            res.store_data  = item.rx_byte;
                            count_next      = sbfr_pkg::LEN_W'(1);
                            collecting_next = 1'b1;
                            tmr_count_next  = '0;
                            tmr_run_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        if (timed_out_reg)
                        begin
                            collecting_next  = 1'b0;
                            timed_out_next   = 1'b0;
                            count_next       = '0;
                            res.timeout_drop = 1'b1;
                        end
                        else
                        begin
                            res.store_valid = 1'b1;
                            res.store_index = count_reg[sbfr_pkg::IDX_W-1:0];
                            res.store_data  = item.rx_byte;
                            count_next      = count_reg + sbfr_pkg::LEN_W'(1);
                        end
                        if (count_next == len)
                        begin
                            held_next       = 1'b1;
                            res.frame_done  = 1'b1;
                            tmr_run_next    = 1'b0;
                            tmr_count_next  = '0;
                            collecting_next = 1'b0;
                        end
                        else
                        begin
                            tmr_count_next = '0;
                            tmr_run_next   = 1'b1;
                        end
                    end
                end
            end
            sbfr_pkg::FUNC_TICK:
            begin
                if (tmr_run_reg)
                begin
                    if (tmr_inc >= lim)
                    begin
                        timed_out_next = 1'b1;
                        tmr_run_next   = 1'b0;
                        tmr_count_next = '0;
                    end
                    else
                    begin
                        tmr_count_next = tmr_inc;
                    end
                end
            end
            sbfr_pkg::FUNC_RELEASE:
            begin
                held_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        res.frame_held = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            held_reg       <= 1'b0;
            timed_out_reg  <= 1'b0;
            tmr_count_reg  <= '0;
            tmr_run_reg    <= 1'b0;
        end
        else if (step)
        begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            held_reg       <= held_next;
            timed_out_reg  <= timed_out_next;
            tmr_count_reg  <= tmr_count_next;
            tmr_run_reg    <= tmr_run_next;
        end
    end

endmodule

/* tb/tb_sync_byte_frame_receiver.sv */
// Self-checking testbench for the sync byte frame receiver: directed and random requests.
module tb_sync_byte_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;

    class frame_scoreboard;
        logic [7:0]                 sync_value;
        logic [sbfr_pkg::LEN_W-1:0] frame_length;
        logic [sbfr_pkg::TMR_W-1:0] timeout_ticks;

        bit                         collecting;
        logic [sbfr_pkg::LEN_W-1:0] byte_count;
        bit                         held;
        bit                         timed_out;
        logic [sbfr_pkg::TMR_W-1:0] timer_count;
        bit                         timer_running;

        sbfr_pkg::out_t             expected_q[$];
        int                         failures;

        function new();
            sync_value    = 8'd0;
            frame_length  = 7'd8;
            timeout_ticks = 16'd100;
            collecting    = 1'b0;
            byte_count    = '0;
            held          = 1'b0;
            timed_out     = 1'b0;
            timer_count   = '0;
            timer_running = 1'b0;
            failures      = 0;
        endfunction

        function void write_reg(logic [sbfr_pkg::CFG_IDX_W-1:0] idx,
                                logic [sbfr_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sbfr_pkg::REG_SYNC_VALUE:    sync_value    = val[7:0];
                sbfr_pkg::REG_FRAME_LENGTH:  frame_length  = val[sbfr_pkg::LEN_W-1:0];
                sbfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks = val[sbfr_pkg::TMR_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned frame_size();
            int unsigned n;
            n = frame_length;
            if (n < 2) n = 2;
            if (n > sbfr_pkg::MAX_FRAME) n = sbfr_pkg::MAX_FRAME;
            return n;
        endfunction

        function void restart_timer();
            timer_count   = '0;
            timer_running = 1'b1;
        endfunction

        // Advance the framer by one accepted request and queue its result.
        function void note_request(sbfr_pkg::in_t req);
            sbfr_pkg::out_t   res;
            int unsigned      lim;
            res = '0;
            case (req.func)
                sbfr_pkg::FUNC_BYTE:
                begin
                    if (!held)
                    begin
                        if (!collecting)
                        begin
                            byte_count = '0;
                            timed_out  = 1'b0;
                            if (req.rx_byte == sync_value)
                            begin
                                res.store_valid = 1'b1;
                                res.store_index = '0;
                                res.store_data  = req.rx_byte;
                                byte_count      = 7'd1;
                                collecting      = 1'b1;
                                restart_timer();
                            end
                        end
                        else
                        begin
                            if (timed_out)
                            begin
                                collecting       = 1'b0;
                                timed_out        = 1'b0;
                                byte_count       = '0;
                                res.timeout_drop = 1'b1;
                            end
                            else
                            begin
                                res.store_valid = 1'b1;
                                res.store_index = byte_count[sbfr_pkg::IDX_W-1:0];
                                res.store_data  = req.rx_byte;
                                byte_count      = byte_count + 7'd1;
                            end
                            if (int'(byte_count) == frame_size())
                            begin
                                held           = 1'b1;
                                res.frame_done = 1'b1;
                                timer_running  = 1'b0;
                                timer_count    = '0;
                                collecting     = 1'b0;
                            end
                            else
                            begin
                                restart_timer();
                            end
                        end
                    end
                end
                sbfr_pkg::FUNC_TICK:
                begin
                    if (timer_running)
                    begin
                        lim = (timeout_ticks == 0) ? 1 : timeout_ticks;
                        timer_count = timer_count + 16'd1;
                        if (timer_count >= lim)
                        begin
                            timed_out     = 1'b1;
                            timer_running = 1'b0;
                            timer_count   = '0;
                        end
                    end
                end
                sbfr_pkg::FUNC_RELEASE: held = 1'b0;
                default: ;
            endcase
            res.frame_held = held;
            expected_q.push_back(res);
        endfunction

        function void check_result(sbfr_pkg::out_t got);
            sbfr_pkg::out_t want;
            string          diff;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no request pending: %p", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            diff = "";
            if (got.store_valid  !== want.store_valid)  diff = {diff, " store_valid"};
            if (got.store_index  !== want.store_index)  diff = {diff, " store_index"};
            if (got.store_data   !== want.store_data)   diff = {diff, " store_data"};
            if (got.frame_done   !== want.frame_done)   diff = {diff, " frame_done"};
            if (got.frame_held   !== want.frame_held)   diff = {diff, " frame_held"};
            if (got.timeout_drop !== want.timeout_drop) diff = {diff, " timeout_drop"};
            if (diff != "")
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: bad%s: expected %p, got %p", $realtime, diff, want, got);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    sbfr_pkg::in_t                   in_data;
    logic                            out_valid;
    logic                            out_ready;
    sbfr_pkg::out_t                  out_data;
    logic                            cfg_write;
    logic [sbfr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sbfr_pkg::CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard       sb = new();
    bit                    in_idle_on;
    bit                    out_idle_on;
    bit                    hold_req;
    int unsigned           cycles;
    int unsigned           sent_items;
    logic [7:0]            cur_sync;
    int unsigned           cur_len;
    int unsigned           cur_tmo;

    sync_byte_frame_receiver i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial
    begin
        int gap;
        int taken;
        out_ready   = 1'b0;
        out_idle_on = 1'b1;
        taken       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = out_idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (taken % 32 == 0)
                out_idle_on = $urandom_range(0, 3) != 0;
        end
    end

    task automatic send_request(logic [1:0] func, logic [7:0] rx);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= sbfr_pkg::in_t'{func: func, rx_byte: rx};
        do @(posedge clk); while (!in_ready);
        if (func != FUNC_UNUSED)
            sent_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [sbfr_pkg::CFG_IDX_W-1:0] idx,
                             logic [sbfr_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(logic [7:0] sync, logic [sbfr_pkg::LEN_W-1:0] len,
                             logic [sbfr_pkg::TMR_W-1:0] tmo);
        write_reg(sbfr_pkg::REG_SYNC_VALUE, sbfr_pkg::CFG_DATA_W'(sync));
        write_reg(sbfr_pkg::REG_FRAME_LENGTH, sbfr_pkg::CFG_DATA_W'(len));
        write_reg(sbfr_pkg::REG_TIMEOUT_TICKS, sbfr_pkg::CFG_DATA_W'(tmo));
        cur_sync = sync;
        cur_len  = (len < 2) ? 2 :
                   ((len > sbfr_pkg::MAX_FRAME) ? sbfr_pkg::MAX_FRAME : len);
        cur_tmo  = (tmo == 0) ? 1 : tmo;
    endtask

    task automatic send_ticks();
        int n;
        if (cur_tmo > 16)
            n = $urandom_range(0, 3);
        else if ($urandom_range(0, 4) == 0)
            n = cur_tmo;
        else
            n = $urandom_range(0, cur_tmo - 1);
        repeat (n) send_request(sbfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 5) == 0) ? cur_sync : 8'($urandom_range(0, 255));
    endfunction

    // Frame led by the sync byte, with random payload and inter-byte ticks that may time it out.
    task automatic send_frame();
        send_request(sbfr_pkg::FUNC_BYTE, cur_sync);
        for (int i = 1; i < cur_len; i++)
        begin
            send_ticks();
            if ($urandom_range(0, 7) == 0)
                send_request(FUNC_UNUSED, pick_byte());
            send_request(sbfr_pkg::FUNC_BYTE, pick_byte());
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_request(sbfr_pkg::FUNC_BYTE, pick_byte());
        if ($urandom_range(0, 11) != 0)
            send_request(sbfr_pkg::FUNC_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_request(2'($urandom_range(0, 3)), pick_byte());
    endtask

    task automatic run_phase(logic [7:0] sync, logic [sbfr_pkg::LEN_W-1:0] len,
                             logic [sbfr_pkg::TMR_W-1:0] tmo, bit hold);
        int unsigned stop_at;
        drain();
        configure(sync, len, tmo);
        stop_at = sent_items + PHASE_ITEMS;
        if (hold)
        begin
            in_idle_on = 1'b0;
            hold_req   = 1'b1;
        end
        while (sent_items < stop_at)
        begin
            if ($urandom_range(0, 3) != 0)
                send_frame();
            else
                send_noise();
            in_idle_on = $urandom_range(0, 3) != 0;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_idle_on = 1'b1;
        hold_req   = 1'b0;
        cycles     = 0;
        sent_items = 0;
        cur_sync   = 8'h00;
        cur_len    = 8;
        cur_tmo    = 100;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: sync 0, length 8
        send_request(sbfr_pkg::FUNC_RELEASE, 8'h00);
        send_request(sbfr_pkg::FUNC_TICK, 8'hFF);
        send_request(FUNC_UNUSED, 8'hFF);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hFF);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h00);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hFF);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h80);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h7F);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h01);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hAA);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h55);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hFE);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h00);
        send_request(FUNC_UNUSED, 8'h00);
        send_request(sbfr_pkg::FUNC_RELEASE, 8'hFF);

        // zero timeout and short length: expiry, drop, stale expiry cleared
        drain();
        configure(8'hFF, 7'd0, 16'd0);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hFF);
        send_request(sbfr_pkg::FUNC_TICK, 8'h00);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h12);
        send_request(sbfr_pkg::FUNC_TICK, 8'h00);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h34);
        send_request(sbfr_pkg::FUNC_BYTE, 8'hFF);
        send_request(sbfr_pkg::FUNC_BYTE, 8'h00);
        send_request(sbfr_pkg::FUNC_RELEASE, 8'h00);

        run_phase(8'hA5, 7'd4, 16'd3, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 7'd1, 16'd1, 1'b1);
        run_phase(8'h00, 7'd127, 16'hFFFF, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 7'($urandom_range(2, 10)),
                  16'($urandom_range(2, 6)), 1'b1);
        run_phase(8'hFF, 7'd5, 16'd0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 7'd64, 16'hFFFF, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 7'($urandom_range(2, 12)),
                  16'($urandom_range(1, 8)), 1'b1);
        run_phase(8'($urandom_range(0, 255)), 7'd2, 16'd2, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
src/sbfr_pkg.sv
src/sbfr_cfg.sv
src/sbfr_core.sv
src/sync_byte_frame_receiver.sv
tb/tb_sync_byte_frame_receiver.sv
